FILE: rtl/cabs_pkg.sv
package cabs_pkg;

  typedef enum logic [3:0] {
    S_LOAD, S_DUMP, S_OUT, S_OR, S_OB, S_OA, S_IN, S_IR, S_IB, S_IC, S_IM, S_IU,
    S_IP, S_IT, S_FIN
  } state_t;

  typedef struct packed {
    logic ins;
    logic shift;
  } cell_ctrl_t;

  localparam logic REG_IOU   = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  localparam logic [15:0] IOU_RESET   = 16'd45875;
  localparam logic [6:0]  LIMIT_RESET = 7'd64;

endpackage

FILE: rtl/cabs_ram.sv
module cabs_ram #(
  parameter int W = 8,
  parameter int D = 256
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/cabs_cell.sv
module cabs_cell #(
  parameter int IW = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cabs_pkg::cell_ctrl_t ctrl,
  input  logic [15:0]          new_score,
  input  logic [IW-1:0]        new_idx,
  input  logic                 prv_valid,
  input  logic                 prv_stay,
  input  logic [15:0]          prv_score,
  input  logic [IW-1:0]        prv_idx,
  input  logic                 nxt_valid,
  input  logic [15:0]          nxt_score,
  input  logic [IW-1:0]        nxt_idx,
  output logic                 valid,
  output logic                 stay,
  output logic [15:0]          score,
  output logic [IW-1:0]        idx
);

  // equal scores stay ahead, so load order holds among ties
  assign stay = valid && (score >= new_score);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= nxt_valid;
      score <= nxt_score;
      idx   <= nxt_idx;
    end else if (ctrl.ins && !stay) begin
      if (prv_stay) begin
        valid <= 1'b1;
        score <= new_score;
        idx   <= new_idx;
      end else begin
        valid <= prv_valid;
        score <= prv_score;
        idx   <= prv_idx;
      end
    end
  end

endmodule

FILE: rtl/class_aware_box_suppression.sv
// load: one beat per cycle while busy is low, each candidate sorted on the fly into a chain
// of rank cells; after the last beat the ranks are copied out (marks cleared alongside), then
// each unmarked rank loads its box and area and opens a pass over the later ranks, where each
// unmarked one of the same class is marked when its IoU exceeds the threshold; the FIN
// state ends the walk and the final beat follows in the next cycle; the receiver cannot stall
// rst clears control state and the config registers; stores need no clearing pass
module class_aware_box_suppression #(
  parameter int MAX_CANDIDATES = 256,
  parameter int MAX_KEPT       = 64,
  parameter int CLASS_BITS     = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] x_min,
  input  logic signed [15:0] y_min,
  input  logic signed [15:0] x_max,
  input  logic signed [15:0] y_max,
  input  logic [15:0]        score,
  input  logic [7:0]         class_id,
  input  logic               last,
  input  logic               wr_en,
  input  logic               wr_index,
  input  logic [15:0]        wr_data,
  output logic               result_strobe,
  output logic [7:0]         kept_index,
  output logic               dropped,
  output logic               last_res
);

  localparam int IW = $clog2(MAX_CANDIDATES);
  localparam int CW = $clog2(MAX_CANDIDATES + 1);
  localparam int BW = 64 + CLASS_BITS;
  localparam logic [CW-1:0] CAP = CW'(MAX_CANDIDATES);
  localparam logic [6:0] KMAX = 7'(MAX_KEPT);

  cabs_pkg::state_t state, state_next;

  logic [15:0]   thr;
  logic [6:0]    klim;
  logic [CW-1:0] lc, n, i, j, d;
  logic          ovf;
  logic [6:0]    count;
  logic          pend_valid;
  logic [IW-1:0] pend_idx, cur_idx;

  logic signed [15:0] bi0, bi1, bi2, bi3, bj0, bj1, bj2, bj3;
  logic [CLASS_BITS-1:0] cls_i, cls_j;
  logic [31:0]  area_i, area_j, inter;
  logic signed [16:0] dx, dy;
  logic [15:0]  wj, hj;
  logic         cls_eq;
  logic signed [33:0] uni;
  logic [48:0]  prod;

  logic accept, store;
  logic [6:0] lim;
  cabs_pkg::cell_ctrl_t ctrl;

  assign busy   = (state != cabs_pkg::S_LOAD);
  assign accept = start && !busy;
  assign store  = accept && (lc < CAP);
  assign lim    = (klim == 7'd0) ? 7'd1 : ((klim > KMAX) ? KMAX : klim);
  assign ctrl.ins   = store;
  assign ctrl.shift = (state == cabs_pkg::S_DUMP);

  // rank chain
  logic          c_valid [MAX_CANDIDATES];
  logic          c_stay  [MAX_CANDIDATES];
  logic [15:0]   c_score [MAX_CANDIDATES];
  logic [IW-1:0] c_idx   [MAX_CANDIDATES];

  for (genvar k = 0; k < MAX_CANDIDATES; k++) begin : g_cell
    logic          p_valid, p_stay, n_valid;
    logic [15:0]   p_score, n_score;
    logic [IW-1:0] p_idx, n_idx;
    if (k == 0) begin : g_head
      assign p_valid = 1'b0;
      assign p_stay  = 1'b1;
      assign p_score = '0;
      assign p_idx   = '0;
    end else begin : g_body
      assign p_valid = c_valid[k-1];
      assign p_stay  = c_stay[k-1];
      assign p_score = c_score[k-1];
      assign p_idx   = c_idx[k-1];
    end
    if (k == MAX_CANDIDATES - 1) begin : g_tail
      assign n_valid = 1'b0;
      assign n_score = '0;
      assign n_idx   = '0;
    end else begin : g_mid
      assign n_valid = c_valid[k+1];
      assign n_score = c_score[k+1];
      assign n_idx   = c_idx[k+1];
    end
    cabs_cell #(.IW(IW)) u_cell (
      .clk(clk), .rst(rst), .ctrl(ctrl),
      .new_score(score), .new_idx(lc[IW-1:0]),
      .prv_valid(p_valid), .prv_stay(p_stay), .prv_score(p_score), .prv_idx(p_idx),
      .nxt_valid(n_valid), .nxt_score(n_score), .nxt_idx(n_idx),
      .valid(c_valid[k]), .stay(c_stay[k]), .score(c_score[k]), .idx(c_idx[k])
    );
  end

  // stores
  logic [IW-1:0] rank_raddr, rank_rdata;
  logic [BW-1:0] box_rdata;

  assign rank_raddr = (state == cabs_pkg::S_OUT) ? i[IW-1:0] : j[IW-1:0];

  cabs_ram #(.W(IW), .D(MAX_CANDIDATES)) u_rank (
    .clk(clk), .we(ctrl.shift), .waddr(d[IW-1:0]), .wdata(c_idx[0]),
    .raddr(rank_raddr), .rdata(rank_rdata)
  );

  cabs_ram #(.W(BW), .D(MAX_CANDIDATES)) u_box (
    .clk(clk), .we(store), .waddr(lc[IW-1:0]),
    .wdata({CLASS_BITS'(class_id), y_max, x_max, y_min, x_min}),
    .raddr(rank_rdata), .rdata(box_rdata)
  );

  // datapath pieces
  logic signed [15:0] x1, y1, x2, y2;
  logic signed [16:0] wi_s, hi_s, wj_s, hj_s;
  logic [15:0] wi, hi;
  logic [49:0] lhs;

  assign x1 = (bi0 > bj0) ? bi0 : bj0;
  assign y1 = (bi1 > bj1) ? bi1 : bj1;
  assign x2 = (bi2 < bj2) ? bi2 : bj2;
  assign y2 = (bi3 < bj3) ? bi3 : bj3;
  assign wi_s = 17'(bi2) - 17'(bi0);
  assign hi_s = 17'(bi3) - 17'(bi1);
  assign wj_s = 17'(bj2) - 17'(bj0);
  assign hj_s = 17'(bj3) - 17'(bj1);
  assign wi = wi_s[16] ? 16'd0 : wi_s[15:0];
  assign hi = hi_s[16] ? 16'd0 : hi_s[15:0];
  assign lhs = {2'b00, inter, 16'd0};

  // suppression marks by rank, cleared while the ranks are copied out
  logic          supp_we, supp_wdata, supp_rdata;
  logic [IW-1:0] supp_waddr;

  assign supp_we    = ctrl.shift || (state == cabs_pkg::S_IT && lhs > {1'b0, prod});
  assign supp_waddr = ctrl.shift ? d[IW-1:0] : j[IW-1:0];
  assign supp_wdata = !ctrl.shift;

  cabs_ram #(.W(1), .D(MAX_CANDIDATES)) u_supp (
    .clk(clk), .we(supp_we), .waddr(supp_waddr), .wdata(supp_wdata),
    .raddr(rank_raddr), .rdata(supp_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= cabs_pkg::S_LOAD;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      cabs_pkg::S_LOAD: if (accept && last) state_next = cabs_pkg::S_DUMP;
      cabs_pkg::S_DUMP: if (d == n - CW'(1)) state_next = cabs_pkg::S_OUT;
      cabs_pkg::S_OUT: begin
        if (i >= n || count >= lim) state_next = cabs_pkg::S_FIN;
        else                        state_next = cabs_pkg::S_OR;
      end
      cabs_pkg::S_OR: begin
        if (supp_rdata) state_next = cabs_pkg::S_OUT;
        else            state_next = cabs_pkg::S_OB;
      end
      cabs_pkg::S_OB: state_next = cabs_pkg::S_OA;
      cabs_pkg::S_OA: state_next = cabs_pkg::S_IN;
      cabs_pkg::S_IN: begin
        if (j >= n) state_next = cabs_pkg::S_OUT;
        else        state_next = cabs_pkg::S_IR;
      end
      cabs_pkg::S_IR: begin
        if (supp_rdata) state_next = cabs_pkg::S_IN;
        else            state_next = cabs_pkg::S_IB;
      end
      cabs_pkg::S_IB: state_next = cabs_pkg::S_IC;
      cabs_pkg::S_IC: state_next = cabs_pkg::S_IM;
      cabs_pkg::S_IM: begin
        if (!cls_eq || dx <= 0 || dy <= 0) state_next = cabs_pkg::S_IN;
        else                               state_next = cabs_pkg::S_IU;
      end
      cabs_pkg::S_IU: state_next = cabs_pkg::S_IP;
      cabs_pkg::S_IP: begin
        if (uni <= 0) state_next = cabs_pkg::S_IN;
        else          state_next = cabs_pkg::S_IT;
      end
      cabs_pkg::S_IT:  state_next = cabs_pkg::S_IN;
      cabs_pkg::S_FIN: state_next = cabs_pkg::S_LOAD;
      default:         state_next = cabs_pkg::S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= cabs_pkg::IOU_RESET;
      klim <= cabs_pkg::LIMIT_RESET;
      lc <= '0;
      ovf <= 1'b0;
      pend_valid <= 1'b0;
      result_strobe <= 1'b0;
      count <= '0;
    end else begin
      result_strobe <= (state == cabs_pkg::S_FIN) ||
                       (state == cabs_pkg::S_OB && pend_valid);
      if (wr_en) begin
        unique case (wr_index)
          cabs_pkg::REG_IOU:   thr  <= wr_data;
          cabs_pkg::REG_LIMIT: klim <= wr_data[6:0];
          default: ;
        endcase
      end
      unique case (state)
        cabs_pkg::S_LOAD: begin
          if (accept) begin
            if (!store) ovf <= 1'b1;
            if (last) begin
              n <= store ? lc + CW'(1) : lc;
              lc <= '0;
              d <= '0;
            end else if (store) begin
              lc <= lc + CW'(1);
            end
          end
        end
        cabs_pkg::S_DUMP: begin
          d <= d + CW'(1);
          i <= '0;
          count <= '0;
        end
        cabs_pkg::S_OUT: ;
        cabs_pkg::S_OR: begin
          if (supp_rdata) i <= i + CW'(1);
          else            cur_idx <= rank_rdata;
        end
        cabs_pkg::S_OB: begin
          {cls_i, bi3, bi2, bi1, bi0} <= box_rdata;
          count <= count + 7'd1;
          // the previous keep is known not to be the final one now
          if (pend_valid) begin
            kept_index <= 8'(pend_idx);
            dropped <= ovf;
            last_res <= 1'b0;
          end
          pend_valid <= 1'b1;
          pend_idx <= cur_idx;
        end
        cabs_pkg::S_OA: begin
          area_i <= wi * hi;
          j <= i + CW'(1);
        end
        cabs_pkg::S_IN: begin
          if (j >= n) i <= i + CW'(1);
        end
        cabs_pkg::S_IR: begin
          if (supp_rdata) j <= j + CW'(1);
        end
        cabs_pkg::S_IB: {cls_j, bj3, bj2, bj1, bj0} <= box_rdata;
        cabs_pkg::S_IC: begin
          dx <= 17'(x2) - 17'(x1);
          dy <= 17'(y2) - 17'(y1);
          wj <= wj_s[16] ? 16'd0 : wj_s[15:0];
          hj <= hj_s[16] ? 16'd0 : hj_s[15:0];
          cls_eq <= (cls_i == cls_j);
        end
        cabs_pkg::S_IM: begin
          if (!cls_eq || dx <= 0 || dy <= 0) j <= j + CW'(1);
          else begin
            inter <= dx[15:0] * dy[15:0];
            area_j <= wj * hj;
          end
        end
        cabs_pkg::S_IU: uni <= $signed({2'b00, area_i}) + $signed({2'b00, area_j})
                               - $signed({2'b00, inter});
        cabs_pkg::S_IP: begin
          if (uni <= 0) j <= j + CW'(1);
          else prod <= thr * uni[32:0];
        end
        cabs_pkg::S_IT: j <= j + CW'(1);
        cabs_pkg::S_FIN: begin
          kept_index <= 8'(pend_idx);
          dropped <= ovf;
          last_res <= 1'b1;
          pend_valid <= 1'b0;
          ovf <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  a_load_cap: assert property (@(posedge clk) disable iff (rst) lc <= CAP)
    else $error("load count beyond capacity");
  a_keep_cap: assert property (@(posedge clk) disable iff (rst) count <= KMAX)
    else $error("more boxes kept than allowed");
  a_final_quiet: assert property (@(posedge clk) disable iff (rst)
      result_strobe && last_res |=> !result_strobe)
    else $error("result beat after the final one");
  a_fin_strobe: assert property (@(posedge clk) disable iff (rst)
      state == cabs_pkg::S_FIN |=> result_strobe && last_res && !busy)
    else $error("final beat missing");

endmodule
